[hw/rtl/nnzm_pkg.sv]
// ----------------------------------------------------------------------------
// nnzm_pkg
// Shared codes for the nearest-neighbor zoom mapper.
// ----------------------------------------------------------------------------
package nnzm_pkg;

	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;
	localparam int SIDE_CFG_W = 13;
	localparam int ZOOM_W = 3;
	localparam int PAN_W  = 16;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_ZOOM_LEVEL   = 3'd2;
	localparam logic [IDX_W-1:0] REG_PAN_X        = 3'd3;
	localparam logic [IDX_W-1:0] REG_PAN_Y        = 3'd4;

	localparam logic [ZOOM_W-1:0] ZOOM_FIT     = 3'd0;
	localparam logic [ZOOM_W-1:0] ZOOM_QUARTER = 3'd1;
	localparam logic [ZOOM_W-1:0] ZOOM_HALF    = 3'd2;
	localparam logic [ZOOM_W-1:0] ZOOM_FULL    = 3'd3;
	localparam logic [ZOOM_W-1:0] ZOOM_DOUBLE  = 3'd4;
	localparam logic [ZOOM_W-1:0] ZOOM_QUAD    = 3'd5;

	typedef enum logic [1:0] {
		KIND_BACKGROUND = 2'd0,
		KIND_IMAGE      = 2'd1,
		KIND_DARK       = 2'd2,
		KIND_LIGHT      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		GEOM_IDLE,
		GEOM_SETUP,
		GEOM_DIV,
		GEOM_OFFS
	} geom_state_t;

endpackage

[hw/rtl/nearest_neighbor_zoom_mapper_core.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_zoom_mapper_core
// Maps a screen pixel to background, border or nearest-neighbor source pixel.
//
//   channel  signals                                   dir
//   in       in_valid, in_stall, screen_x, screen_y    word in
//   out      out_valid, out_stall, pixel_kind, source_x, source_y,
//            source_address                            word out
//   cfg      wr_en, wr_index, wr_data                  register write
//
// One word per cycle while in_stall is low. A word passes s1 to s3, then the
// pipelined divider (one quotient bit per stage), then s4 and s5.
// After reset and after every register write in_stall stays high while the
// geometry is recomputed: setup, then in fit mode when the image does not fit
// the divide state, then the offset state. out_stall freezes the whole
// pipeline while out_valid is high; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module nearest_neighbor_zoom_mapper_core #(
	parameter int DISPLAY_WIDTH  = 640,
	parameter int AREA_HEIGHT    = 480,
	parameter int MAX_IMAGE_SIDE = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [nnzm_pkg::IDX_W-1:0]   wr_index,
	input  logic [nnzm_pkg::CFG_W-1:0]   wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [9:0]                   screen_x,
	input  logic [8:0]                   screen_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   pixel_kind,
	output logic [11:0]                  source_x,
	output logic [11:0]                  source_y,
	output logic [23:0]                  source_address
);
	import nnzm_pkg::*;

	localparam int SW   = $clog2(MAX_IMAGE_SIDE + 1);
	localparam int DW   = SW + 2;
	localparam int QW   = $clog2(MAX_IMAGE_SIDE);
	localparam int PW   = DW + SW;
	localparam int AMAX = (DISPLAY_WIDTH > AREA_HEIGHT) ? DISPLAY_WIDTH : AREA_HEIGHT;
	localparam int AWW  = $clog2(AMAX + 1);
	localparam int MW   = (DW > AWW) ? DW : AWW;
	localparam int OW   = ((MW > 16) ? MW : 16) + 3;
	localparam int XW   = OW + 1;
	localparam int MAW  = SW + SW;

	logic                 busy;
	logic [SW-1:0]        iw, ih;
	logic [DW-1:0]        dw, dh;
	logic signed [OW-1:0] x0, y0;
	logic                 en;

	nnzm_geom #(
		.DISPLAY_WIDTH (DISPLAY_WIDTH),
		.AREA_HEIGHT   (AREA_HEIGHT),
		.MAX_IMAGE_SIDE(MAX_IMAGE_SIDE),
		.SW(SW), .DW(DW), .OW(OW)
	) u_geom (
		.clk, .arst_n, .wr_en, .wr_index, .wr_data,
		.busy, .iw, .ih, .dw, .dh, .x0, .y0
	);

	assign en       = !(out_valid && out_stall);
	assign in_stall = busy || !en;

	// s1: input
	logic       vl_s1;
	logic [9:0] sx_s1;
	logic [8:0] sy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vl_s1 <= 1'b0;
		else if (en)
			vl_s1 <= in_valid && !busy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= screen_x;
			sy_s1 <= screen_y;
		end
	end

	// s2: offsets into the image
	logic                 vl_s2, area_s2;
	logic signed [XW-1:0] dx_s2, dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vl_s2 <= 1'b0;
		else if (en)
			vl_s2 <= vl_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			area_s2 <= (32'(sx_s1) < DISPLAY_WIDTH) && (32'(sy_s1) < AREA_HEIGHT);
			dx_s2 <= $signed({{(XW-10){1'b0}}, sx_s1}) - $signed({x0[OW-1], x0});
			dy_s2 <= $signed({{(XW-9){1'b0}}, sy_s1}) - $signed({y0[OW-1], y0});
		end
	end

	// s3: classification and scaled products
	logic signed [XW-1:0] dwe, dhe, m1;
	logic                 light, dark, img;
	kind_t                kind_c;

	assign dwe = $signed({{(XW-DW){1'b0}}, dw});
	assign dhe = $signed({{(XW-DW){1'b0}}, dh});
	assign m1  = $signed({XW{1'b1}});

	// later border lines win: light over dark
	assign light = (dy_s2 == dhe && dx_s2 >= m1 && dx_s2 <= dwe)
		|| (dx_s2 == dwe && dy_s2 >= m1 && dy_s2 <= dhe);
	assign dark = (dy_s2 == m1 && dx_s2 >= m1 && dx_s2 <= dwe)
		|| (dx_s2 == m1 && dy_s2 >= m1 && dy_s2 <= dhe);
	assign img = dx_s2 >= 0 && dx_s2 < dwe && dy_s2 >= 0 && dy_s2 < dhe;

	always_comb begin
		if (!area_s2)
			kind_c = KIND_BACKGROUND;
		else if (light)
			kind_c = KIND_LIGHT;
		else if (dark)
			kind_c = KIND_DARK;
		else if (img)
			kind_c = KIND_IMAGE;
		else
			kind_c = KIND_BACKGROUND;
	end

	logic          vl_s3;
	kind_t         kind_s3;
	logic [PW-1:0] px_s3, py_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vl_s3 <= 1'b0;
		else if (en)
			vl_s3 <= vl_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind_c;
			px_s3 <= (kind_c == KIND_IMAGE) ? PW'(dx_s2[DW-1:0]) * PW'(iw) : '0;
			py_s3 <= (kind_c == KIND_IMAGE) ? PW'(dy_s2[DW-1:0]) * PW'(ih) : '0;
		end
	end

	logic          vl_dv;
	kind_t         kind_dv;
	logic [QW-1:0] cx_dv, cy_dv;

	nnzm_div #(.SW(SW), .DW(DW), .QW(QW)) u_div (
		.clk, .arst_n, .en,
		.in_vld (vl_s3),
		.in_kind(kind_s3),
		.px     (px_s3),
		.py     (py_s3),
		.dw, .dh,
		.out_vld (vl_dv),
		.out_kind(kind_dv),
		.cx      (cx_dv),
		.cy      (cy_dv)
	);

	// s4: clamp and row offset
	logic [SW-1:0]  cxc, cyc;
	logic           vl_s4;
	kind_t          kind_s4;
	logic [SW-1:0]  cx_s4, cy_s4;
	logic [MAW-1:0] row_s4;

	assign cxc = (SW'(cx_dv) >= iw) ? iw - SW'(1) : SW'(cx_dv);
	assign cyc = (SW'(cy_dv) >= ih) ? ih - SW'(1) : SW'(cy_dv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vl_s4 <= 1'b0;
		else if (en)
			vl_s4 <= vl_dv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4 <= kind_dv;
			cx_s4   <= (kind_dv == KIND_IMAGE) ? cxc : '0;
			cy_s4   <= (kind_dv == KIND_IMAGE) ? cyc : '0;
			row_s4  <= (kind_dv == KIND_IMAGE) ? MAW'(cyc) * MAW'(iw) : '0;
		end
	end

	// s5: output word
	logic           vl_s5;
	kind_t          kind_s5;
	logic [SW-1:0]  cx_s5, cy_s5;
	logic [MAW-1:0] addr_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vl_s5 <= 1'b0;
		else if (en)
			vl_s5 <= vl_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s5 <= kind_s4;
			cx_s5   <= cx_s4;
			cy_s5   <= cy_s4;
			addr_s5 <= row_s4 + MAW'(cx_s4);
		end
	end

	assign out_valid      = vl_s5;
	assign pixel_kind     = kind_s5;
	assign source_x       = 12'(cx_s5);
	assign source_y       = 12'(cy_s5);
	assign source_address = 24'(addr_s5);

	// geometry recompute must hold off input
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("input open during geometry update");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stall && !busy) |-> (out_valid && out_stall))
		else $error("input stalled without cause");

	a_src_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pixel_kind == KIND_IMAGE) |->
		(32'(cx_s5) < 32'(iw) && 32'(cy_s5) < 32'(ih)))
		else $error("source coordinate beyond image");

	a_non_image_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pixel_kind != KIND_IMAGE) |->
		(source_x == '0 && source_y == '0 && source_address == '0))
		else $error("non-image word carries source data");

endmodule

[hw/rtl/nnzm_geom.sv]
// ----------------------------------------------------------------------------
// nnzm_geom
// Configuration registers and display geometry: displayed size and image
// origin, recomputed after every write (fit mode: a shift-subtract divider).
// ----------------------------------------------------------------------------
module nnzm_geom #(
	parameter int DISPLAY_WIDTH  = 640,
	parameter int AREA_HEIGHT    = 480,
	parameter int MAX_IMAGE_SIDE = 4096,
	parameter int SW = 13,
	parameter int DW = 15,
	parameter int OW = 19
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [nnzm_pkg::IDX_W-1:0]   wr_index,
	input  logic [nnzm_pkg::CFG_W-1:0]   wr_data,
	output logic                         busy,
	output logic [SW-1:0]                iw,
	output logic [SW-1:0]                ih,
	output logic [DW-1:0]                dw,
	output logic [DW-1:0]                dh,
	output logic signed [OW-1:0]         x0,
	output logic signed [OW-1:0]         y0
);
	import nnzm_pkg::*;

	localparam int AMAX = (DISPLAY_WIDTH > AREA_HEIGHT) ? DISPLAY_WIDTH : AREA_HEIGHT;
	localparam int AWW  = $clog2(AMAX + 1);
	localparam int NW   = SW + AWW;
	localparam int CW   = $clog2(NW);

	logic [SIDE_CFG_W-1:0] width_q, height_q;
	logic [ZOOM_W-1:0]     zoom_q;
	logic [PAN_W-1:0]      pan_x_q, pan_y_q;

	geom_state_t state_q, state_d;

	logic [SW-1:0] iw_cl, ih_cl;
	logic          fits, need_div, limit_w;
	logic [NW-1:0] cross_l, cross_r;
	logic [DW-1:0] pdw, pdh;

	logic [NW-1:0] num_q;
	logic [SW-1:0] den_q;
	logic [SW-1:0] rem_q;
	logic [SW:0]   trial;
	logic          qbit;
	logic [CW-1:0] cnt_q;
	logic          to_h_q;

	logic signed [OW-1:0] dif_x, dif_y, tmp_x, tmp_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_CFG_W'(1);
			height_q <= SIDE_CFG_W'(1);
			zoom_q   <= ZOOM_FIT;
			pan_x_q  <= '0;
			pan_y_q  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_IMAGE_WIDTH:  width_q  <= wr_data[SIDE_CFG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= wr_data[SIDE_CFG_W-1:0];
				REG_ZOOM_LEVEL:   zoom_q   <= wr_data[ZOOM_W-1:0];
				REG_PAN_X:        pan_x_q  <= wr_data[PAN_W-1:0];
				REG_PAN_Y:        pan_y_q  <= wr_data[PAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			iw_cl = SW'(1);
		else if (32'(width_q) > MAX_IMAGE_SIDE)
			iw_cl = SW'(MAX_IMAGE_SIDE);
		else
			iw_cl = SW'(width_q);
		if (height_q == '0)
			ih_cl = SW'(1);
		else if (32'(height_q) > MAX_IMAGE_SIDE)
			ih_cl = SW'(MAX_IMAGE_SIDE);
		else
			ih_cl = SW'(height_q);
	end

	assign fits    = (32'(iw_cl) <= DISPLAY_WIDTH) && (32'(ih_cl) <= AREA_HEIGHT);
	assign cross_l = NW'(ih_cl) * NW'(DISPLAY_WIDTH);
	assign cross_r = NW'(iw_cl) * NW'(AREA_HEIGHT);
	assign limit_w = cross_l < cross_r;
	assign need_div = (zoom_q == ZOOM_FIT) && !fits;

	always_comb begin
		case (zoom_q)
			ZOOM_QUARTER: begin
				pdw = DW'(iw_cl >> 2);
				pdh = DW'(ih_cl >> 2);
			end
			ZOOM_HALF: begin
				pdw = DW'(iw_cl >> 1);
				pdh = DW'(ih_cl >> 1);
			end
			ZOOM_DOUBLE: begin
				pdw = DW'(iw_cl) << 1;
				pdh = DW'(ih_cl) << 1;
			end
			ZOOM_QUAD: begin
				pdw = DW'(iw_cl) << 2;
				pdh = DW'(ih_cl) << 2;
			end
			default: begin
				pdw = DW'(iw_cl);
				pdh = DW'(ih_cl);
			end
		endcase
	end

	// one quotient bit per cycle in GEOM_DIV
	assign trial = {rem_q, num_q[NW-1]};
	assign qbit  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= GEOM_SETUP;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		unique case (state_q)
			GEOM_IDLE: begin
				busy = 1'b0;
				if (wr_en)
					state_d = GEOM_SETUP;
			end
			GEOM_SETUP: begin
				if (wr_en)
					state_d = GEOM_SETUP;
				else if (need_div)
					state_d = GEOM_DIV;
				else
					state_d = GEOM_OFFS;
			end
			GEOM_DIV: begin
				if (wr_en)
					state_d = GEOM_SETUP;
				else if (cnt_q == '0)
					state_d = GEOM_OFFS;
			end
			GEOM_OFFS: begin
				state_d = wr_en ? GEOM_SETUP : GEOM_IDLE;
			end
			default: state_d = GEOM_SETUP;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			GEOM_SETUP: begin
				iw <= iw_cl;
				ih <= ih_cl;
				rem_q <= '0;
				cnt_q <= CW'(NW - 1);
				to_h_q <= limit_w;
				if (zoom_q != ZOOM_FIT) begin
					dw <= pdw;
					dh <= pdh;
				end else if (fits) begin
					dw <= DW'(iw_cl);
					dh <= DW'(ih_cl);
				end else if (limit_w) begin
					dw <= DW'(DISPLAY_WIDTH);
					num_q <= cross_l;
					den_q <= iw_cl;
				end else begin
					dh <= DW'(AREA_HEIGHT);
					num_q <= cross_r;
					den_q <= ih_cl;
				end
			end
			GEOM_DIV: begin
				rem_q <= qbit ? SW'(trial - {1'b0, den_q}) : SW'(trial);
				num_q <= {num_q[NW-2:0], qbit};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					if (to_h_q)
						dh <= DW'({num_q[NW-2:0], qbit});
					else
						dw <= DW'({num_q[NW-2:0], qbit});
				end
			end
			GEOM_OFFS: begin
				x0 <= (tmp_x >>> 1) + $signed({{(OW-PAN_W){pan_x_q[PAN_W-1]}}, pan_x_q});
				y0 <= (tmp_y >>> 1) + $signed({{(OW-PAN_W){pan_y_q[PAN_W-1]}}, pan_y_q});
			end
			default: ;
		endcase
	end

	// centering truncates toward zero
	always_comb begin
		dif_x = $signed(OW'(DISPLAY_WIDTH)) - $signed({{(OW-DW){1'b0}}, dw});
		dif_y = $signed(OW'(AREA_HEIGHT)) - $signed({{(OW-DW){1'b0}}, dh});
		tmp_x = dif_x + $signed({{(OW-1){1'b0}}, dif_x[OW-1]});
		tmp_y = dif_y + $signed({{(OW-1){1'b0}}, dif_y[OW-1]});
	end

endmodule

[hw/rtl/nnzm_div.sv]
// ----------------------------------------------------------------------------
// nnzm_div
// Pipelined restoring divider, two lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module nnzm_div #(
	parameter int SW = 13,
	parameter int DW = 15,
	parameter int QW = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  nnzm_pkg::kind_t       in_kind,
	input  logic [DW+SW-1:0]      px,
	input  logic [DW+SW-1:0]      py,
	input  logic [DW-1:0]         dw,
	input  logic [DW-1:0]         dh,
	output logic                  out_vld,
	output nnzm_pkg::kind_t       out_kind,
	output logic [QW-1:0]         cx,
	output logic [QW-1:0]         cy
);
	import nnzm_pkg::*;

	localparam int PW = DW + SW;

	logic [PW-1:0] rx_s [QW+1];
	logic [PW-1:0] ry_s [QW+1];
	logic [QW-1:0] qx_s [QW+1];
	logic [QW-1:0] qy_s [QW+1];
	kind_t         kd_s [QW+1];
	logic          vl_s [QW+1];

	assign rx_s[0] = px;
	assign ry_s[0] = py;
	assign qx_s[0] = '0;
	assign qy_s[0] = '0;
	assign kd_s[0] = in_kind;
	assign vl_s[0] = in_vld;

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [PW-1:0] shx, shy;
		logic          gx, gy;

		assign shx = PW'(dw) << (QW - k);
		assign shy = PW'(dh) << (QW - k);
		assign gx  = rx_s[k-1] >= shx;
		assign gy  = ry_s[k-1] >= shy;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vl_s[k] <= 1'b0;
			else if (en)
				vl_s[k] <= vl_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k] <= gx ? rx_s[k-1] - shx : rx_s[k-1];
				ry_s[k] <= gy ? ry_s[k-1] - shy : ry_s[k-1];
				qx_s[k] <= qx_s[k-1] | (QW'(gx) << (QW - k));
				qy_s[k] <= qy_s[k-1] | (QW'(gy) << (QW - k));
				kd_s[k] <= kd_s[k-1];
			end
		end
	end

	assign out_vld  = vl_s[QW];
	assign out_kind = kd_s[QW];
	assign cx       = qx_s[QW];
	assign cy       = qy_s[QW];

endmodule

[verif/nearest_neighbor_zoom_mapper_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_zoom_mapper_core_test
// Self-checking bench: runs screen words through the mapper under several
// geometry settings with random input gaps and random output back-pressure.
// Every result is compared field by field with a local model of the mapping.
// ----------------------------------------------------------------------------
module nearest_neighbor_zoom_mapper_core_test;
	import nnzm_pkg::*;

	localparam int DISP_W = 640;
	localparam int AREA_H = 480;
	localparam int MAX_SIDE = 4096;
	localparam int DRAIN_CYCLES = 64;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [9:0] sx;
		logic [8:0] sy;
	} screen_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] srcx;
		logic [11:0] srcy;
		logic [23:0] addr;
	} map_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [9:0] screen_x = '0;
	logic [8:0] screen_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] pixel_kind;
	logic [11:0] source_x, source_y;
	logic [23:0] source_address;

	screen_word_t pending_words[$];
	map_word_t expected_maps[$];

	logic [12:0] cfg_width = 13'd1;
	logic [12:0] cfg_height = 13'd1;
	logic [2:0] cfg_zoom = ZOOM_FIT;
	logic [15:0] cfg_pan_x = '0;
	logic [15:0] cfg_pan_y = '0;

	int mismatches = 0;
	int checked = 0;
	int settings_run = 0;
	longint cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_cycles = 0;
	bit hold_request = 1'b0;
	bit stim_done = 1'b0;

	always #4 clk = ~clk;

	nearest_neighbor_zoom_mapper_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.screen_x(screen_x), .screen_y(screen_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_kind(pixel_kind), .source_x(source_x), .source_y(source_y),
		.source_address(source_address)
	);

	function automatic longint trunc_div(longint a, longint b);
		longint q;
		q = (a < 0 ? -a : a) / b;
		return (a < 0) ? -q : q;
	endfunction

	function automatic map_word_t map_pixel(screen_word_t w);
		longint iw, ih, dw, dh, x0, y0, dx, dy, pct, cx, cy;
		map_word_t r;
		r = '0;
		iw = (cfg_width == 0) ? 1 : (cfg_width > MAX_SIDE ? MAX_SIDE : cfg_width);
		ih = (cfg_height == 0) ? 1 : (cfg_height > MAX_SIDE ? MAX_SIDE : cfg_height);
		if (cfg_zoom == ZOOM_FIT) begin
			if (DISP_W >= iw && AREA_H >= ih) begin
				dw = iw;
				dh = ih;
			end else if (DISP_W * ih < AREA_H * iw) begin
				dw = DISP_W;
				dh = (ih * DISP_W) / iw;
			end else begin
				dh = AREA_H;
				dw = (iw * AREA_H) / ih;
			end
		end else begin
			case (cfg_zoom)
				ZOOM_QUARTER: pct = 25;
				ZOOM_HALF:    pct = 50;
				ZOOM_DOUBLE:  pct = 200;
				ZOOM_QUAD:    pct = 400;
				default:      pct = 100;
			endcase
			dw = (iw * pct) / 100;
			dh = (ih * pct) / 100;
		end
		x0 = trunc_div(DISP_W - dw, 2) + longint'($signed(cfg_pan_x));
		y0 = trunc_div(AREA_H - dh, 2) + longint'($signed(cfg_pan_y));
		if (w.sx < DISP_W && w.sy < AREA_H) begin
			dx = longint'(w.sx) - x0;
			dy = longint'(w.sy) - y0;
			if ((dy == dh && dx >= -1 && dx <= dw) || (dx == dw && dy >= -1 && dy <= dh))
				r.kind = KIND_LIGHT;
			else if ((dy == -1 && dx >= -1 && dx <= dw) ||
					(dx == -1 && dy >= -1 && dy <= dh))
				r.kind = KIND_DARK;
			else if (dx >= 0 && dx < dw && dy >= 0 && dy < dh) begin
				cx = (dx * iw) / dw;
				cy = (dy * ih) / dh;
				if (cx >= iw) cx = iw - 1;
				if (cy >= ih) cy = ih - 1;
				r.kind = KIND_IMAGE;
				r.srcx = cx[11:0];
				r.srcy = cy[11:0];
				r.addr = 24'(cy * iw + cx);
			end
		end
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		int gap;
		cycles <= cycles + 1;
		if (in_valid && !in_stall) begin
			expected_maps.push_back(map_pixel({screen_x, screen_y}));
			gap = $urandom_range(0, 15);
			if (gap == 0 && pending_words.size() > 0)
				{screen_x, screen_y} <= pending_words.pop_front();
			else begin
				in_valid <= 1'b0;
				send_gap <= (gap > 0) ? gap - 1 : 0;
			end
		end else if (!in_valid && pending_words.size() > 0) begin
			if (send_gap > 0)
				send_gap <= send_gap - 1;
			else begin
				{screen_x, screen_y} <= pending_words.pop_front();
				in_valid <= 1'b1;
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (hold_request && hold_cycles == 0) begin
			hold_cycles <= 400;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= (hold_cycles > 1);
		end else if (out_valid && !out_stall) begin
			recv_gap <= $urandom_range(0, 15);
			out_stall <= ($urandom_range(0, 3) == 0);
		end else if (out_stall) begin
			if (recv_gap > 0)
				recv_gap <= recv_gap - 1;
			else
				out_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		map_word_t want;
		if (out_valid && !out_stall) begin
			if (expected_maps.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected word kind=%0d", pixel_kind);
			end else begin
				want = expected_maps.pop_front();
				checked <= checked + 1;
				if (want != {pixel_kind, source_x, source_y, source_address}) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch exp k=%0d x=%0d y=%0d a=%0d got k=%0d x=%0d y=%0d a=%0d",
							want.kind, want.srcx, want.srcy, want.addr,
							pixel_kind, source_x, source_y, source_address);
				end
			end
		end
	end

	task automatic wait_idle();
		while (pending_words.size() > 0 || in_valid || expected_maps.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  cfg_width = val[12:0];
			REG_IMAGE_HEIGHT: cfg_height = val[12:0];
			REG_ZOOM_LEVEL:   cfg_zoom = val[2:0];
			REG_PAN_X:        cfg_pan_x = val;
			REG_PAN_Y:        cfg_pan_y = val;
			default: ;
		endcase
	endtask

	task automatic set_geometry(int w, int h, int z, int px, int py);
		write_reg(REG_IMAGE_WIDTH, 16'(w));
		write_reg(REG_IMAGE_HEIGHT, 16'(h));
		write_reg(REG_ZOOM_LEVEL, 16'(z));
		write_reg(REG_PAN_X, 16'(px));
		write_reg(REG_PAN_Y, 16'(py));
		settings_run++;
	endtask

	// random words biased toward the image and its border
	task automatic queue_random(int n);
		screen_word_t w;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: w = {10'($urandom), 9'($urandom)};
				1, 2: w = {10'($urandom_range(0, 639)), 9'($urandom_range(0, 479))};
				default: w = {10'($urandom_range(280, 360)), 9'($urandom_range(200, 280))};
			endcase
			pending_words.push_back(w);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: field extremes and out-of-area words at reset geometry
		pending_words.push_back({10'd0, 9'd0});
		pending_words.push_back({10'd639, 9'd479});
		pending_words.push_back({10'd640, 9'd0});
		pending_words.push_back({10'd1023, 9'd511});
		pending_words.push_back({10'd0, 9'd480});
		for (int dx = 318; dx <= 321; dx++)
			for (int dy = 238; dy <= 241; dy++)
				pending_words.push_back({10'(dx), 9'(dy)});
		wait_idle();
		// zero size, undefined zoom and saturated sides
		set_geometry(3, 3, ZOOM_QUARTER, 0, 0);
		for (int dx = 318; dx <= 321; dx++)
			pending_words.push_back({10'(dx), 9'd239});
		wait_idle();
		set_geometry(0, 8191, 7, 0, 0);
		queue_random(20);
		wait_idle();
		for (int s = 0; s < 24; s++) begin
			case (s % 6)
				0: set_geometry($urandom_range(1, 4096), $urandom_range(1, 4096),
					ZOOM_FIT, 0, 0);
				1: set_geometry(4096, 4096, ZOOM_QUAD, -32768, 32767);
				2: set_geometry(1, 1, ZOOM_DOUBLE, $urandom_range(0, 20) - 10,
					$urandom_range(0, 20) - 10);
				default: set_geometry($urandom_range(1, 200), $urandom_range(1, 200),
					$urandom_range(0, 7), $urandom_range(0, 60) - 30,
					$urandom_range(0, 60) - 30);
			endcase
			if (s == 5) hold_request = 1'b1;
			queue_random(52);
			if (s == 5) wait (hold_cycles > 0);
			hold_request = 1'b0;
			wait_idle();
		end
		$display("checked %0d mapped words over %0d geometry settings", checked, settings_run);
		$display("settings covered fit, all zoom codes, saturated sides and extreme pans");
		if (mismatches == 0 && expected_maps.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		@(posedge arst_n);
	end
endmodule
